// ----- rtl/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, widths and constants for the battery power sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  // field widths
  localparam int MV_W   = 15;
  localparam int STAY_W = 16;
  localparam int LVL_W  = 10;
  localparam int CNT_W  = 16;
  localparam int UP_W   = 32;
  localparam int KIND_W = 2;
  localparam int SEL_W  = 2;

  // stream widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 120;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // reset values
  localparam logic [CNT_W-1:0]  INIT_PU_DELAY      = 16'd5;
  localparam logic [CNT_W-1:0]  RST_SD_RELOAD      = 16'd60;
  localparam logic [CNT_W-1:0]  RST_PU_RELOAD      = 16'd60;
  localparam logic [CNT_W-1:0]  RST_FORCED_DELAY   = 16'd60;
  localparam logic [STAY_W-1:0] RST_STAY_ON_MV     = 16'd34463;
  localparam logic [MV_W-1:0]   RST_OFF_THRESH_MV  = 15'd11000;
  localparam logic [MV_W-1:0]   RST_ON_THRESH_MV   = 15'd12500;
  localparam logic [LVL_W-1:0]  RST_SW_OFF_BELOW   = 10'd300;
  localparam logic [LVL_W-1:0]  RST_SW_FORCED_BELOW = 10'd700;

  // event kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_MEASURE = 2'd1,
    KIND_WRITE   = 2'd2
  } kind_t;

  // host write targets
  typedef enum logic [SEL_W-1:0] {
    SEL_SHUTDOWN = 2'd0,
    SEL_POWERUP  = 2'd1,
    SEL_REBOOT   = 2'd2,
    SEL_WATCHDOG = 2'd3
  } sel_t;

  // switch modes
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_FORCED = 2'd1,
    MODE_AUTO   = 2'd2
  } mode_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_SD_RELOAD     = 3'd0,
    REG_PU_RELOAD     = 3'd1,
    REG_FORCED_DELAY  = 3'd2,
    REG_STAY_ON_MV    = 3'd3,
    REG_OFF_THRESH_MV = 3'd4,
    REG_ON_THRESH_MV  = 3'd5,
    REG_SW_OFF_BELOW  = 3'd6,
    REG_SW_FORCED_BELOW = 3'd7
  } reg_idx_t;

  // configuration set
  typedef struct packed {
    logic [CNT_W-1:0]  shutdown_reload;
    logic [CNT_W-1:0]  powerup_reload;
    logic [CNT_W-1:0]  forced_on_shutdown_delay;
    logic [STAY_W-1:0] stay_on_mv;
    logic [MV_W-1:0]   off_threshold_mv;
    logic [MV_W-1:0]   on_threshold_mv;
    logic [LVL_W-1:0]  switch_off_below;
    logic [LVL_W-1:0]  switch_forced_below;
  } cfg_t;

  // one input item
  typedef struct packed {
    kind_t             kind;
    logic [MV_W-1:0]   battery_mv;
    logic [LVL_W-1:0]  switch_level;
    sel_t              counter_select;
    logic [CNT_W-1:0]  write_value;
  } item_t;

  // sequencer state, also the result snapshot
  typedef struct packed {
    logic              power_on;
    mode_t             switch_mode;
    logic [MV_W-1:0]   filtered_mv;
    logic [CNT_W-1:0]  shutdown_left;
    logic [CNT_W-1:0]  powerup_left;
    logic [CNT_W-1:0]  reboot_left;
    logic [CNT_W-1:0]  watchdog_left;
    logic              shutdown_wanted;
    logic              powerup_wanted;
    logic              reset_wanted;
    logic [UP_W-1:0]   uptime_ticks;
  } state_t;

endpackage

// ----- rtl/bps_cfg.sv -----
// ----------------------------------------------------------------------------
// bps_cfg
// APB register file holding the thresholds and reload values.
// ----------------------------------------------------------------------------
module bps_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bps_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [bps_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output bps_pkg::cfg_t                   cfg
);

  bps_pkg::cfg_t     cfg_r;
  bps_pkg::reg_idx_t idx;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = bps_pkg::reg_idx_t'(cfg_paddr[bps_pkg::CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shutdown_reload          <= bps_pkg::RST_SD_RELOAD;
      cfg_r.powerup_reload           <= bps_pkg::RST_PU_RELOAD;
      cfg_r.forced_on_shutdown_delay <= bps_pkg::RST_FORCED_DELAY;
      cfg_r.stay_on_mv               <= bps_pkg::RST_STAY_ON_MV;
      cfg_r.off_threshold_mv         <= bps_pkg::RST_OFF_THRESH_MV;
      cfg_r.on_threshold_mv          <= bps_pkg::RST_ON_THRESH_MV;
      cfg_r.switch_off_below         <= bps_pkg::RST_SW_OFF_BELOW;
      cfg_r.switch_forced_below      <= bps_pkg::RST_SW_FORCED_BELOW;
    end else if (wr_en) begin
      case (idx)
        bps_pkg::REG_SD_RELOAD:
          cfg_r.shutdown_reload <= cfg_pwdata[bps_pkg::CNT_W-1:0];
        bps_pkg::REG_PU_RELOAD:
          cfg_r.powerup_reload <= cfg_pwdata[bps_pkg::CNT_W-1:0];
        bps_pkg::REG_FORCED_DELAY:
          cfg_r.forced_on_shutdown_delay <= cfg_pwdata[bps_pkg::CNT_W-1:0];
        bps_pkg::REG_STAY_ON_MV:
          cfg_r.stay_on_mv <= cfg_pwdata[bps_pkg::STAY_W-1:0];
        bps_pkg::REG_OFF_THRESH_MV:
          cfg_r.off_threshold_mv <= cfg_pwdata[bps_pkg::MV_W-1:0];
        bps_pkg::REG_ON_THRESH_MV:
          cfg_r.on_threshold_mv <= cfg_pwdata[bps_pkg::MV_W-1:0];
        bps_pkg::REG_SW_OFF_BELOW:
          cfg_r.switch_off_below <= cfg_pwdata[bps_pkg::LVL_W-1:0];
        bps_pkg::REG_SW_FORCED_BELOW:
          cfg_r.switch_forced_below <= cfg_pwdata[bps_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (idx)
      bps_pkg::REG_SD_RELOAD:       cfg_prdata = 32'(cfg_r.shutdown_reload);
      bps_pkg::REG_PU_RELOAD:       cfg_prdata = 32'(cfg_r.powerup_reload);
      bps_pkg::REG_FORCED_DELAY:    cfg_prdata = 32'(cfg_r.forced_on_shutdown_delay);
      bps_pkg::REG_STAY_ON_MV:      cfg_prdata = 32'(cfg_r.stay_on_mv);
      bps_pkg::REG_OFF_THRESH_MV:   cfg_prdata = 32'(cfg_r.off_threshold_mv);
      bps_pkg::REG_ON_THRESH_MV:    cfg_prdata = 32'(cfg_r.on_threshold_mv);
      bps_pkg::REG_SW_OFF_BELOW:    cfg_prdata = 32'(cfg_r.switch_off_below);
      bps_pkg::REG_SW_FORCED_BELOW: cfg_prdata = 32'(cfg_r.switch_forced_below);
      default:                      cfg_prdata = '0;
    endcase
  end

endmodule

// ----- rtl/bps_in_reg.sv -----
// ----------------------------------------------------------------------------
// bps_in_reg
// Input stage: unpacks the stream item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module bps_in_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bps_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [bps_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           take,
  output logic                           item_valid,
  output bps_pkg::item_t                 item
);

  logic           valid_r;
  logic           valid_nxt;
  bps_pkg::item_t item_r;
  bps_pkg::item_t item_nxt;
  logic           load;

  // stage frees up when empty or when the core takes the item
  assign in_tready  = !valid_r || take;
  assign load       = in_tvalid && in_tready;
  assign item_valid = valid_r;
  assign item       = item_r;

  // unpack: tdata = battery_mv, switch_level, write_value; tuser = kind, select
  always_comb begin
    item_nxt.kind           = bps_pkg::kind_t'(in_tuser[1:0]);
    item_nxt.counter_select = bps_pkg::sel_t'(in_tuser[3:2]);
    item_nxt.battery_mv     = in_tdata[14:0];
    item_nxt.switch_level   = in_tdata[24:15];
    item_nxt.write_value    = in_tdata[40:25];
  end

  always_comb begin
    valid_nxt = load || (valid_r && !take);
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- rtl/bps_core.sv -----
// ----------------------------------------------------------------------------
// bps_core
// Sequencer state and its combinational update, registered on fire, for one
// tick, measurement or host counter write.
// ----------------------------------------------------------------------------
module bps_core #(
  parameter logic [bps_pkg::CNT_W-1:0] INITIAL_POWERUP_DELAY = bps_pkg::INIT_PU_DELAY
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  bps_pkg::item_t  item,
  input  bps_pkg::cfg_t   cfg,
  output bps_pkg::state_t state_next
);

  bps_pkg::state_t     state_r;
  bps_pkg::state_t     state_nxt;
  logic [18:0]         filt_acc;
  logic [bps_pkg::MV_W-1:0] filt_new;

  // (15*old + new)/16 as (old<<4) - old + new, then drop four bits
  assign filt_acc = {state_r.filtered_mv, 4'b0000} - {4'b0000, state_r.filtered_mv}
                  + {4'b0000, item.battery_mv};
  assign filt_new = filt_acc[18:4];

  always_comb begin
    state_nxt = state_r;
    case (item.kind)
      // one-second tick
      bps_pkg::KIND_TICK: begin
        if (state_r.power_on && state_r.shutdown_left != '0) begin
          if ({1'b0, state_r.filtered_mv} < cfg.stay_on_mv) begin
            state_nxt.shutdown_left = state_r.shutdown_left - 1'b1;
          end
          if (state_nxt.shutdown_left == '0) begin
            state_nxt.shutdown_wanted = 1'b1;
          end
        end
        if (state_r.reboot_left != '0) begin
          state_nxt.reboot_left = state_r.reboot_left - 1'b1;
          if (state_nxt.reboot_left == '0) begin
            state_nxt.reset_wanted = 1'b1;
          end
        end
        if (state_r.watchdog_left != '0) begin
          state_nxt.watchdog_left = state_r.watchdog_left - 1'b1;
          if (state_nxt.watchdog_left == '0) begin
            state_nxt.reset_wanted = 1'b1;
          end
        end
        if (!state_r.power_on && state_r.powerup_left != '0) begin
          state_nxt.powerup_left = state_r.powerup_left - 1'b1;
          if (state_nxt.powerup_left == '0) begin
            state_nxt.powerup_wanted = 1'b1;
          end
        end
        state_nxt.uptime_ticks = state_r.uptime_ticks + 1'b1;
      end
      // measurement: filter, classify switch, hysteresis
      bps_pkg::KIND_MEASURE: begin
        state_nxt.filtered_mv = filt_new;
        if (item.switch_level < cfg.switch_off_below) begin
          state_nxt.switch_mode    = bps_pkg::MODE_OFF;
          state_nxt.power_on       = 1'b0;
          state_nxt.powerup_wanted = 1'b1;
        end else if (item.switch_level < cfg.switch_forced_below) begin
          state_nxt.switch_mode    = bps_pkg::MODE_FORCED;
          state_nxt.power_on       = 1'b1;
          state_nxt.powerup_wanted = 1'b1;
          state_nxt.shutdown_left  = cfg.forced_on_shutdown_delay;
        end else begin
          state_nxt.switch_mode = bps_pkg::MODE_AUTO;
          if (state_r.power_on) begin
            // low voltage or pending shutdown switches off
            if (filt_new < cfg.off_threshold_mv || state_r.shutdown_wanted) begin
              state_nxt.shutdown_wanted = 1'b0;
              state_nxt.powerup_wanted  = 1'b0;
              state_nxt.powerup_left    = cfg.powerup_reload;
              state_nxt.power_on        = 1'b0;
            end
          end else if (state_r.powerup_wanted && filt_new >= cfg.on_threshold_mv) begin
            state_nxt.powerup_wanted  = 1'b0;
            state_nxt.shutdown_wanted = 1'b0;
            state_nxt.shutdown_left   = cfg.shutdown_reload;
            state_nxt.power_on        = 1'b1;
          end
        end
      end
      // host counter write
      bps_pkg::KIND_WRITE: begin
        case (item.counter_select)
          bps_pkg::SEL_SHUTDOWN: state_nxt.shutdown_left = item.write_value;
          bps_pkg::SEL_POWERUP:  state_nxt.powerup_left  = item.write_value;
          bps_pkg::SEL_REBOOT:   state_nxt.reboot_left   = item.write_value;
          bps_pkg::SEL_WATCHDOG: state_nxt.watchdog_left = item.write_value;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign state_next = state_nxt;

  // state update per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.power_on        <= 1'b0;
      state_r.switch_mode     <= bps_pkg::MODE_AUTO;
      state_r.filtered_mv     <= bps_pkg::RST_ON_THRESH_MV;
      state_r.shutdown_left   <= bps_pkg::RST_FORCED_DELAY;
      state_r.powerup_left    <= INITIAL_POWERUP_DELAY;
      state_r.reboot_left     <= '0;
      state_r.watchdog_left   <= '0;
      state_r.shutdown_wanted <= 1'b0;
      state_r.powerup_wanted  <= 1'b0;
      state_r.reset_wanted    <= 1'b0;
      state_r.uptime_ticks    <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/bps_out_reg.sv -----
// ----------------------------------------------------------------------------
// bps_out_reg
// Result register: packs the state snapshot onto the output stream.
// ----------------------------------------------------------------------------
module bps_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  bps_pkg::state_t                 result,
  output logic                            free,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bps_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic                             valid_r;
  logic                             valid_nxt;
  logic [bps_pkg::OUT_DATA_W-1:0]   data_r;
  logic [bps_pkg::OUT_DATA_W-1:0]   data_nxt;

  // slot can take a new result when empty or being drained
  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  // pack from bit 0: power_on, switch_mode, filtered_mv, four counters,
  // shutdown/powerup/reset wanted, uptime, zero pad
  always_comb begin
    data_nxt = {3'b000,
                result.uptime_ticks,
                result.reset_wanted,
                result.powerup_wanted,
                result.shutdown_wanted,
                result.watchdog_left,
                result.reboot_left,
                result.powerup_left,
                result.shutdown_left,
                result.filtered_mv,
                result.switch_mode,
                result.power_on};
    valid_nxt = load || (valid_r && !out_tready);
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- rtl/battery_power_sequencer.sv -----
// ----------------------------------------------------------------------------
// battery_power_sequencer
// Path from input accept to result valid: input register, then state update
// into result register. Throughput: one item per cycle while the result
// register is free to take it (stalls when out_tready holds a full slot).
// Reset (rst_n low, synchronous): state and configuration registers take their reset
// values, both stages empty.
// ----------------------------------------------------------------------------
module battery_power_sequencer #(
  parameter logic [bps_pkg::CNT_W-1:0] INITIAL_POWERUP_DELAY = bps_pkg::INIT_PU_DELAY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // battery_mv[14:0], switch_level[24:15], write_value[40:25], zero pad
  input  logic [bps_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind[1:0], counter_select[3:2]
  input  logic [bps_pkg::IN_USER_W-1:0]   in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // power_on[0], switch_mode[2:1], filtered_mv[17:3], shutdown_left[33:18],
  // powerup_left[49:34], reboot_left[65:50], watchdog_left[81:66],
  // shutdown_wanted[82], powerup_wanted[83], reset_wanted[84],
  // uptime_ticks[116:85], zero pad
  output logic [bps_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bps_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [bps_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  bps_pkg::cfg_t   cfg;
  bps_pkg::item_t  item;
  bps_pkg::state_t state_next;
  logic            item_valid;
  logic            out_free;
  logic            fire;

  // core consumes the held item when the result slot is free
  assign fire = item_valid && out_free;

  bps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bps_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  bps_core #(
    .INITIAL_POWERUP_DELAY (INITIAL_POWERUP_DELAY)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (item),
    .cfg        (cfg),
    .state_next (state_next)
  );

  bps_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (state_next),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
